// ===== src/ring_lwe_ciphertext_product_top_defines.svh =====
// ============================================================================
// Assertion macros for the ring-LWE ciphertext product block
// Shared concurrent assertion forms used by the port checker.
// ============================================================================
`ifndef RING_LWE_CIPHERTEXT_PRODUCT_TOP_DEFINES_SVH
`define RING_LWE_CIPHERTEXT_PRODUCT_TOP_DEFINES_SVH

// same-cycle implication
`define RLCP_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rlcp port check failed");

// next-cycle implication
`define RLCP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rlcp port check failed");

`endif

// ===== src/rlcp_pkg.sv =====
// ============================================================================
// rlcp_pkg
// Types and codes shared by the ring-LWE ciphertext product block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package rlcp_pkg;

   localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
   localparam logic [1:0] CMD_READ        = 2'd2;
   localparam logic [1:0] CMD_UNUSED      = 2'd3;

   localparam logic [1:0] REG_MODULUS       = 2'd0;
   localparam logic [1:0] REG_RING_DEGREE   = 2'd1;
   localparam logic [1:0] REG_FIRST_LENGTH  = 2'd2;
   localparam logic [1:0] REG_SECOND_LENGTH = 2'd3;

   localparam logic [31:0] MODULUS_RESET = 32'd65537;
   localparam logic [10:0] DEGREE_RESET  = 11'd1024;
   localparam logic [2:0]  LENGTH_RESET  = 3'd2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [2:0]         component_index;
      logic [9:0]         coefficient_index;
      logic signed [31:0] coefficient_value;
   } req_type;

   typedef struct packed {
      logic [2:0]         product_component;
      logic [9:0]         product_coefficient;
      logic signed [31:0] product_value;
   } rsp_type;

   // control from sequencer to modular multiply unit
   typedef struct packed {
      logic start;
      logic negate;
   } mac_ctrl_type;

   // status from modular multiply unit
   typedef struct packed {
      logic        done;
      logic [31:0] value;
   } mac_stat_type;

endpackage

`default_nettype wire

// ===== src/ring_lwe_ciphertext_product_top.sv =====
// ============================================================================
// ring_lwe_ciphertext_product_top
// Negacyclic product of two ring-LWE ciphertexts, one coefficient per read.
// ============================================================================
// Usage:
//  - csr_* writes modulus, ring degree and both ciphertext lengths; write only
//    while the block is idle.
//  - req_* carries one transaction per command. Loads (first or second
//    operand) are written when accepted and give no response. A read names a
//    product component and power and gives exactly one rsp_* transaction.
//  - Reads run through the stored operands one term at a time: each term
//    is a memory fetch (S_ADDR, S_WAIT) plus a pass of the serial modular
//    multiply unit (S_MAC). rsp_valid rises once every valid component pair
//    has been summed; an out-of-range read goes straight to S_FINISH.
//  - req_stall is high while a read is in progress; one read at a time.
//  - The response sits in an output register; a stalled response holds and
//    loads are still accepted behind it. A second read computes fully and
//    waits for the register to free up.
//  - Reset (synchronous) restores register defaults and clears control;
//    operand memories are not cleared and must be loaded before use.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ring_lwe_ciphertext_product_top #(
   parameter int MAX_DEGREE     = 1024,
   parameter int MAX_COMPONENTS = 4,
   parameter int COEFF_BITS     = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire rlcp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rlcp_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [31:0]       csr_wdata
);

   localparam int DEPTH = MAX_COMPONENTS * MAX_DEGREE;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW    = $clog2(MAX_DEGREE + 1);
   localparam int LW    = $clog2(MAX_COMPONENTS + 1);

   // sequencer states
   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_COMP   = 6'b000010,
      S_ADDR   = 6'b000100,
      S_WAIT   = 6'b001000,
      S_MAC    = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   // configuration registers
   logic [31:0] modulus_ff;
   logic [10:0] degree_ff;
   logic [2:0]  len1_ff, len2_ff;

   state_type         state_ff, state_in;
   logic [2:0]        comp_ff, comp_in;
   logic [9:0]        pow_ff, pow_in;
   logic [LW-1:0]     i_ff, i_in;
   logic [NW-1:0]     a_ff, a_in;
   logic [31:0]       acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rlcp_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // effective (clamped) configuration
   logic [31:0]   q_eff;
   logic [NW-1:0] n_eff;
   logic [LW-1:0] l1_eff, l2_eff;

   logic                  req_accept, is_load, load_ok;
   logic                  we1, we2;
   logic [AW-1:0]         addr1, addr2;
   logic [COEFF_BITS-1:0] rdata1, rdata2;
   logic                  i_valid, wrap, range_ok, i_last, a_last, out_free;
   int                    j_int, b_int;
   logic [32:0]           acc_sum;

   rlcp_pkg::mac_ctrl_type mac_ctrl;
   rlcp_pkg::mac_stat_type mac_stat;

   // ---------------------------------------------------------------------
   // configuration
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= rlcp_pkg::MODULUS_RESET;
         degree_ff  <= rlcp_pkg::DEGREE_RESET;
         len1_ff    <= rlcp_pkg::LENGTH_RESET;
         len2_ff    <= rlcp_pkg::LENGTH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            rlcp_pkg::REG_MODULUS:       modulus_ff <= csr_wdata;
            rlcp_pkg::REG_RING_DEGREE:   degree_ff  <= csr_wdata[10:0];
            rlcp_pkg::REG_FIRST_LENGTH:  len1_ff    <= csr_wdata[2:0];
            rlcp_pkg::REG_SECOND_LENGTH: len2_ff    <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      q_eff = (modulus_ff < 32'd2) ? 32'd2 : modulus_ff;
      if (degree_ff == 11'd0) begin
         n_eff = NW'(1);
      end else if (int'(degree_ff) > MAX_DEGREE) begin
         n_eff = NW'(MAX_DEGREE);
      end else begin
         n_eff = NW'(degree_ff);
      end
      if (len1_ff == 3'd0) begin
         l1_eff = LW'(1);
      end else if (int'(len1_ff) > MAX_COMPONENTS) begin
         l1_eff = LW'(MAX_COMPONENTS);
      end else begin
         l1_eff = LW'(len1_ff);
      end
      if (len2_ff == 3'd0) begin
         l2_eff = LW'(1);
      end else if (int'(len2_ff) > MAX_COMPONENTS) begin
         l2_eff = LW'(MAX_COMPONENTS);
      end else begin
         l2_eff = LW'(len2_ff);
      end
   end

   // ---------------------------------------------------------------------
   // operand stores: loads write at the accept edge, reads come from the
   // sequencer (never both, loads only land while idle)
   // ---------------------------------------------------------------------
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign is_load    = (req_data.cmd == rlcp_pkg::CMD_LOAD_FIRST) ||
                       (req_data.cmd == rlcp_pkg::CMD_LOAD_SECOND);
   assign load_ok    = (int'(req_data.component_index) < MAX_COMPONENTS) &&
                       (int'(req_data.coefficient_index) < MAX_DEGREE);
   assign we1 = req_accept && load_ok && (req_data.cmd == rlcp_pkg::CMD_LOAD_FIRST);
   assign we2 = req_accept && load_ok && (req_data.cmd == rlcp_pkg::CMD_LOAD_SECOND);

   // term indexing: j = comp - i, b = pow - a, wrapped past x^n when a > pow
   always_comb begin
      j_int   = int'(comp_ff) - int'(i_ff);
      i_valid = (int'(i_ff) <= int'(comp_ff)) && (j_int < int'(l2_eff));
      wrap    = int'(a_ff) > int'(pow_ff);
      b_int   = wrap ? int'(pow_ff) + int'(n_eff) - int'(a_ff)
                     : int'(pow_ff) - int'(a_ff);
      if (req_stall) begin
         addr1 = AW'(int'(i_ff) * MAX_DEGREE + int'(a_ff));
         addr2 = AW'(j_int * MAX_DEGREE + b_int);
      end else begin
         addr1 = AW'(int'(req_data.component_index) * MAX_DEGREE +
                     int'(req_data.coefficient_index));
         addr2 = addr1;
      end
   end

   rlcp_store #(
      .DEPTH (DEPTH),
      .WIDTH (COEFF_BITS),
      .AW    (AW)
   ) u_first_store (
      .clock (clock),
      .we    (we1),
      .addr  (addr1),
      .wdata (req_data.coefficient_value[COEFF_BITS-1:0]),
      .rdata (rdata1)
   );

   rlcp_store #(
      .DEPTH (DEPTH),
      .WIDTH (COEFF_BITS),
      .AW    (AW)
   ) u_second_store (
      .clock (clock),
      .we    (we2),
      .addr  (addr2),
      .wdata (req_data.coefficient_value[COEFF_BITS-1:0]),
      .rdata (rdata2)
   );

   // ---------------------------------------------------------------------
   // serial modular multiply, started once the fetched pair is valid
   // ---------------------------------------------------------------------
   assign mac_ctrl.start  = (state_ff == S_WAIT);
   assign mac_ctrl.negate = wrap;

   rlcp_modmac #(
      .COEFF_BITS (COEFF_BITS)
   ) u_modmac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .x_val   (rdata1),
      .y_val   (rdata2),
      .modulus (q_eff),
      .stat    (mac_stat)
   );

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   assign range_ok = (int'(req_data.component_index) <
                      int'(l1_eff) + int'(l2_eff) - 1) &&
                     (int'(req_data.coefficient_index) < int'(n_eff));
   assign i_last   = (i_ff == l1_eff - 1'b1);
   assign a_last   = (a_ff == n_eff - 1'b1);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign acc_sum  = {1'b0, acc_ff} + {1'b0, mac_stat.value};

   always_comb begin
      state_in     = state_ff;
      comp_in      = comp_ff;
      pow_in       = pow_ff;
      i_in         = i_ff;
      a_in         = a_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && !is_load && req_data.cmd == rlcp_pkg::CMD_READ) begin
               comp_in  = req_data.component_index;
               pow_in   = req_data.coefficient_index;
               i_in     = '0;
               acc_in   = '0;
               state_in = range_ok ? S_COMP : S_FINISH;
            end
         end
         S_COMP: begin
            a_in = '0;
            if (i_valid) begin
               state_in = S_ADDR;
            end else if (i_last) begin
               state_in = S_FINISH;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         S_ADDR: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            state_in = S_MAC;
         end
         S_MAC: begin
            if (mac_stat.done) begin
               acc_in = (acc_sum >= {1'b0, q_eff}) ? 32'(acc_sum - {1'b0, q_eff})
                                                    : acc_sum[31:0];
               if (!a_last) begin
                  a_in     = a_ff + 1'b1;
                  state_in = S_ADDR;
               end else if (i_last) begin
                  state_in = S_FINISH;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_COMP;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in                     = 1'b1;
               rsp_data_in.product_component    = comp_ff;
               rsp_data_in.product_coefficient  = pow_ff;
               // center into (-q/2, q/2]
               rsp_data_in.product_value = (acc_ff > (q_eff >> 1)) ? acc_ff - q_eff
                                                                    : acc_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      comp_ff     <= comp_in;
      pow_ff      <= pow_in;
      i_ff        <= i_in;
      a_ff        <= a_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== src/rlcp_store.sv =====
// ============================================================================
// rlcp_store
// Single-port synchronous coefficient memory, registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rlcp_store #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 32,
   parameter int AW    = 12
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

`default_nettype wire

// ===== src/rlcp_modmac.sv =====
// ============================================================================
// rlcp_modmac
// Bit-serial signed modular multiply: reduces |y| mod q, then shift-add
// multiplies by |x| mod q; sign applied at the end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rlcp_modmac #(
   parameter int COEFF_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire rlcp_pkg::mac_ctrl_type    ctrl,
   input  wire logic [COEFF_BITS-1:0]     x_val,
   input  wire logic [COEFF_BITS-1:0]     y_val,
   input  wire logic [31:0]               modulus,
   output rlcp_pkg::mac_stat_type         stat
);

   localparam int CW = (COEFF_BITS > 1) ? $clog2(COEFF_BITS) : 1;

   typedef enum logic [3:0] {
      U_IDLE = 4'b0001,
      U_RED  = 4'b0010,
      U_MUL  = 4'b0100,
      U_DONE = 4'b1000
   } ustate_type;

   ustate_type            state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [COEFF_BITS-1:0] xmag_ff, xmag_in;
   logic [COEFF_BITS-1:0] ymag_ff, ymag_in;
   logic                  neg_ff, neg_in;
   logic [31:0]           yres_ff, yres_in;
   logic [31:0]           acc_ff, acc_in;

   logic [32:0] red_sum;
   logic [33:0] mul_sum, mul_s1, mul_s2;
   logic        last;

   assign last = (cnt_ff == CW'(COEFF_BITS - 1));

   always_comb begin
      red_sum = {yres_ff, ymag_ff[COEFF_BITS-1]};
      if (red_sum >= {1'b0, modulus}) begin
         red_sum = red_sum - {1'b0, modulus};
      end
      mul_sum = {1'b0, acc_ff, 1'b0} +
                (xmag_ff[COEFF_BITS-1] ? {2'b00, yres_ff} : 34'd0);
      mul_s1 = (mul_sum >= {2'b00, modulus}) ? mul_sum - {2'b00, modulus} : mul_sum;
      mul_s2 = (mul_s1 >= {2'b00, modulus}) ? mul_s1 - {2'b00, modulus} : mul_s1;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      xmag_in  = xmag_ff;
      ymag_in  = ymag_ff;
      neg_in   = neg_ff;
      yres_in  = yres_ff;
      acc_in   = acc_ff;
      case (state_ff)
         U_IDLE: begin
            if (ctrl.start) begin
               xmag_in  = x_val[COEFF_BITS-1] ? ~x_val + 1'b1 : x_val;
               ymag_in  = y_val[COEFF_BITS-1] ? ~y_val + 1'b1 : y_val;
               neg_in   = x_val[COEFF_BITS-1] ^ y_val[COEFF_BITS-1] ^ ctrl.negate;
               yres_in  = '0;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = U_RED;
            end
         end
         U_RED: begin
            yres_in = red_sum[31:0];
            ymag_in = {ymag_ff[COEFF_BITS-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            if (last) begin
               cnt_in   = '0;
               state_in = U_MUL;
            end
         end
         U_MUL: begin
            acc_in  = mul_s2[31:0];
            xmag_in = {xmag_ff[COEFF_BITS-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            if (last) begin
               state_in = U_DONE;
            end
         end
         U_DONE: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      xmag_ff <= xmag_in;
      ymag_ff <= ymag_in;
      neg_ff  <= neg_in;
      yres_ff <= yres_in;
      acc_ff  <= acc_in;
   end

   assign stat.done  = (state_ff == U_DONE);
   assign stat.value = (neg_ff && acc_ff != 32'd0) ? modulus - acc_ff : acc_ff;

endmodule

`default_nettype wire

// ===== src/rlcp_checker.sv =====
// ============================================================================
// rlcp_checker
// Port-level assertions for the ring-LWE ciphertext product block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "ring_lwe_ciphertext_product_top_defines.svh"

module rlcp_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire rlcp_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire rlcp_pkg::rsp_type rsp_data
);

   // held response stays put
   `RLCP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   // a read transaction makes the block busy in the next cycle
   `RLCP_ASSERT_NEXT(a_read_busy, clock, reset, req_valid && !req_stall && req_data.cmd == rlcp_pkg::CMD_READ, req_stall)
   // a response only appears out of a busy period
   `RLCP_ASSERT_NOW(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(req_stall))
   // nothing pending right after reset
   `RLCP_ASSERT_NOW(a_reset_clear, clock, 1'b0, $fell(reset), !rsp_valid && !req_stall)

endmodule

bind ring_lwe_ciphertext_product_top rlcp_checker u_rlcp_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
// ============================================================================
// tb - ring-LWE ciphertext product testbench
// Loads both operand stores with bursty, stalled traffic and checks each
// product read against an in-bench negacyclic product over several
// modulus, degree and length settings, the clamped extremes among them.
// ============================================================================
`timescale 1ns / 1ps

module tb;

   localparam int MAX_DEG   = 1024;
   localparam int MAX_COMP  = 4;
   localparam longint CYCLE_LIMIT = 4000000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   rlcp_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rlcp_pkg::rsp_type rsp_data;
   logic              csr_write = 1'b0;
   logic [1:0]        csr_index = rlcp_pkg::REG_MODULUS;
   logic [31:0]       csr_wdata = '0;

   ring_lwe_ciphertext_product_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // operand stores and register copies mirrored from the block
   logic signed [31:0] first_store  [0:MAX_COMP*MAX_DEG-1];
   logic signed [31:0] second_store [0:MAX_COMP*MAX_DEG-1];
   logic [31:0] mod_reg    = rlcp_pkg::MODULUS_RESET;
   logic [10:0] degree_reg = rlcp_pkg::DEGREE_RESET;
   logic [2:0]  len1_reg   = rlcp_pkg::LENGTH_RESET;
   logic [2:0]  len2_reg   = rlcp_pkg::LENGTH_RESET;

   rlcp_pkg::req_type pending_q [$];   // transactions not yet offered
   rlcp_pkg::rsp_type product_q [$];   // product coefficients owed by the block
   int      error_count = 0;
   longint  cycle_count = 0;

   function automatic longint unsigned residue(logic signed [31:0] v,
                                               longint unsigned q);
      longint s;
      s = longint'(v) % longint'(q);
      if (s < 0) s += longint'(q);
      return longint'(s);
   endfunction

   function automatic int clamp_len(logic [2:0] l);
      if (l == 0) return 1;
      if (l > MAX_COMP) return MAX_COMP;
      return int'(l);
   endfunction

   function automatic int eff_degree();
      if (degree_reg == 0) return 1;
      if (degree_reg > MAX_DEG) return MAX_DEG;
      return int'(degree_reg);
   endfunction

   // centered coefficient of x^pow in component comp of the negacyclic product
   function automatic logic [31:0] product_coeff(int comp, int pow);
      longint unsigned q, acc, x, y, p;
      int n, l1, l2, j, b;
      q   = (mod_reg < 32'd2) ? 64'd2 : {32'd0, mod_reg};
      n   = eff_degree();
      l1  = clamp_len(len1_reg);
      l2  = clamp_len(len2_reg);
      acc = 0;
      if (comp < l1 + l2 - 1 && pow < n) begin
         for (int i = 0; i < l1 && i <= comp; i++) begin
            j = comp - i;
            if (j >= l2) continue;
            for (int a = 0; a < n; a++) begin
               b = (a > pow) ? pow + n - a : pow - a;
               x = residue(first_store[i*MAX_DEG + a], q);
               y = residue(second_store[j*MAX_DEG + b], q);
               p = (x * y) % q;
               acc = (a > pow) ? (acc + q - p) % q : (acc + p) % q;
            end
         end
      end
      if (acc > q / 2) acc = acc - q;
      return acc[31:0];
   endfunction

   // mirror one accepted transaction into the stores or the owed queue
   task automatic track_request(rlcp_pkg::req_type r);
      rlcp_pkg::rsp_type e;
      if (r.cmd == rlcp_pkg::CMD_LOAD_FIRST || r.cmd == rlcp_pkg::CMD_LOAD_SECOND) begin
         if (r.component_index < MAX_COMP) begin
            if (r.cmd == rlcp_pkg::CMD_LOAD_FIRST)
               first_store[r.component_index*MAX_DEG + r.coefficient_index] =
                  r.coefficient_value;
            else
               second_store[r.component_index*MAX_DEG + r.coefficient_index] =
                  r.coefficient_value;
         end
      end else if (r.cmd == rlcp_pkg::CMD_READ) begin
         e.product_component   = r.component_index;
         e.product_coefficient = r.coefficient_index;
         e.product_value       = product_coeff(int'(r.component_index),
                                               int'(r.coefficient_index));
         product_q.push_back(e);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Driver: bursts of random length, random gaps; payload held while stalled.
   // ---------------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 1;
         gap_left   <= 0;
      end else begin
         if (req_valid && !req_stall) track_request(req_data);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               req_data  <= pending_q.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver stall: mode drawn at random from none, light and heavy.
   // ---------------------------------------------------------------------------
   int stall_mode = 0;

   always @(posedge clock) begin
      if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // ---------------------------------------------------------------------------
   // Monitor: each response transaction against the oldest owed product.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rlcp_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (product_q.size() == 0) begin
            $error("unexpected response component=%0d coefficient=%0d value=%0d",
                   rsp_data.product_component, rsp_data.product_coefficient,
                   rsp_data.product_value);
            error_count++;
         end else begin
            e = product_q.pop_front();
            if (rsp_data.product_component !== e.product_component) begin
               $error("product_component expected %0d got %0d",
                      e.product_component, rsp_data.product_component);
               error_count++;
            end
            if (rsp_data.product_coefficient !== e.product_coefficient) begin
               $error("product_coefficient expected %0d got %0d",
                      e.product_coefficient, rsp_data.product_coefficient);
               error_count++;
            end
            if (rsp_data.product_value !== e.product_value) begin
               $error("product_value expected %0d got %0d",
                      e.product_value, rsp_data.product_value);
               error_count++;
            end
         end
      end
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic logic [31:0] pick_coeff();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   function automatic rlcp_pkg::req_type make_req(logic [1:0] cmd, int comp, int pow,
                                                  logic [31:0] val);
      rlcp_pkg::req_type r;
      r.cmd               = cmd;
      r.component_index   = comp[2:0];
      r.coefficient_index = pow[9:0];
      r.coefficient_value = val;
      return r;
   endfunction

   // block is idle: nothing queued, held or owed; then let loads drain
   task automatic wait_idle();
      while (pending_q.size() > 0 || req_valid || product_q.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_regs(logic [31:0] q, logic [10:0] deg,
                             logic [2:0] l1, logic [2:0] l2);
      @(posedge clock);
      csr_write <= 1'b1; csr_index <= rlcp_pkg::REG_MODULUS; csr_wdata <= q;
      mod_reg = q;
      @(posedge clock);
      csr_index <= rlcp_pkg::REG_RING_DEGREE;   csr_wdata <= {21'd0, deg};
      degree_reg = deg;
      @(posedge clock);
      csr_index <= rlcp_pkg::REG_FIRST_LENGTH;  csr_wdata <= {29'd0, l1};
      len1_reg = l1;
      @(posedge clock);
      csr_index <= rlcp_pkg::REG_SECOND_LENGTH; csr_wdata <= {29'd0, l2};
      len2_reg = l2;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // every entry a read under the current setting can touch gets written
   task automatic load_operands();
      for (int c = 0; c < clamp_len(len1_reg); c++)
         for (int a = 0; a < eff_degree(); a++)
            pending_q.push_back(make_req(rlcp_pkg::CMD_LOAD_FIRST, c, a, pick_coeff()));
      for (int c = 0; c < clamp_len(len2_reg); c++)
         for (int a = 0; a < eff_degree(); a++)
            pending_q.push_back(make_req(rlcp_pkg::CMD_LOAD_SECOND, c, a, pick_coeff()));
   endtask

   task automatic push_random(int count);
      int n, ncomp, sel;
      n     = eff_degree();
      ncomp = clamp_len(len1_reg) + clamp_len(len2_reg) - 1;
      for (int k = 0; k < count; k++) begin
         sel = $urandom_range(0, 9);
         if (sel == 0) begin
            // noise: unused command or load outside the stores
            if ($urandom_range(0, 1))
               pending_q.push_back(make_req(rlcp_pkg::CMD_UNUSED, $urandom_range(0, 7),
                                            $urandom_range(0, 1023), $urandom));
            else
               pending_q.push_back(make_req(2'($urandom_range(0, 1)),
                                            $urandom_range(4, 7),
                                            $urandom_range(0, 1023), $urandom));
         end else if (sel <= 4) begin
            pending_q.push_back(make_req(2'($urandom_range(0, 1)),
                                         $urandom_range(0, MAX_COMP - 1),
                                         $urandom_range(0, 1023), pick_coeff()));
         end else if (sel == 5) begin
            pending_q.push_back(make_req(rlcp_pkg::CMD_READ, $urandom_range(0, 7),
                                         $urandom_range(0, 1023), $urandom));
         end else begin
            pending_q.push_back(make_req(rlcp_pkg::CMD_READ, $urandom_range(0, ncomp - 1),
                                         $urandom_range(0, n - 1), $urandom));
         end
      end
   endtask

   task automatic run_phase(logic [31:0] q, logic [10:0] deg, logic [2:0] l1,
                            logic [2:0] l2, int count);
      wait_idle();
      write_regs(q, deg, l1, l2);
      load_operands();
      push_random(count);
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: every component, edge powers, extremes, ignored commands
      write_regs(rlcp_pkg::MODULUS_RESET, 11'd4, 3'd2, 3'd2);
      load_operands();
      pending_q.push_back(make_req(rlcp_pkg::CMD_LOAD_FIRST, 0, 3, 32'h8000_0000));
      pending_q.push_back(make_req(rlcp_pkg::CMD_LOAD_SECOND, 1, 3, 32'h7FFF_FFFF));
      pending_q.push_back(make_req(rlcp_pkg::CMD_LOAD_FIRST, 7, 1023, 32'hFFFF_FFFF));
      pending_q.push_back(make_req(rlcp_pkg::CMD_LOAD_SECOND, 4, 1023, 32'h1234_5678));
      pending_q.push_back(make_req(rlcp_pkg::CMD_UNUSED, 7, 1023, 32'hFFFF_FFFF));
      for (int c = 0; c < 8; c++)
         pending_q.push_back(make_req(rlcp_pkg::CMD_READ, c, 3, 32'hFFFF_FFFF));
      pending_q.push_back(make_req(rlcp_pkg::CMD_READ, 0, 0, 32'h0));
      pending_q.push_back(make_req(rlcp_pkg::CMD_READ, 1, 0, 32'h0));
      pending_q.push_back(make_req(rlcp_pkg::CMD_READ, 2, 1, 32'h0));
      pending_q.push_back(make_req(rlcp_pkg::CMD_READ, 0, 1023, 32'h0));
      pending_q.push_back(make_req(rlcp_pkg::CMD_READ, 1, 4, 32'h0));
      push_random(6);

      // clamped settings: modulus 0, degree 0, length 0 and 7
      run_phase(32'd0, 11'd0, 3'd0, 3'd7, 8);
      run_phase(32'd1, 11'd2, 3'd4, 3'd4, 8);
      run_phase(32'hFFFF_FFFF, 11'd5, 3'd4, 3'd1, 6);
      run_phase($urandom, 11'($urandom_range(1, 4)), 3'($urandom_range(0, 7)),
                3'($urandom_range(0, 7)), 6);
      run_phase(32'($urandom_range(2, 300)), 11'($urandom_range(1, 4)),
                3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 6);

      wait_idle();
      repeat (200) @(posedge clock);
      if (error_count == 0 && product_q.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
